FILE: design/pdd_pkg.sv
// Package for the planar delta image decoder: sizes, command codes, register indexes
// and the operation record passed from the front end to the back end.
// Depends on nothing; every other design file refers to it by scoped names.
package pdd_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int RING_DEPTH  = MAX_WIDTH + 1;
   localparam int RING_AW     = $clog2(RING_DEPTH);
   localparam int DIM_W       = 13;
   localparam int INDEX_W     = 25;
   localparam int TOTAL_W     = 2 * DIM_W;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   localparam logic [DIM_W-1:0] ROW_WIDTH_RESET = 13'd1024;
   localparam logic [DIM_W-1:0] ROW_COUNT_RESET = 13'd768;

   localparam logic CSR_ROW_WIDTH = 1'b0;
   localparam logic CSR_ROW_COUNT = 1'b1;

   localparam logic [7:0] SLOT_MASK [4] = '{8'h03, 8'h0C, 8'h30, 8'hC0};

   typedef enum logic [1:0] {
      CMD_RAW  = 2'd0,
      CMD_CODE = 2'd1,
      CMD_DATA = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      WCODE_ONE   = 2'd0,
      WCODE_TWO   = 2'd1,
      WCODE_FOUR  = 2'd2,
      WCODE_SKIP  = 2'd3
   } wcode_type;

   typedef struct packed {
      logic               is_delta;
      logic               last;
      logic [31:0]        value;
      logic [RING_AW-1:0] wr_addr;
      logic [RING_AW-1:0] up_addr;
      logic [RING_AW-1:0] ul_addr;
   } op_type;

endpackage

FILE: design/planar_delta_image_decoder.sv
// Top level of the planar delta image decoder: front end, operation queue, back end.
// Depends on pdd_pkg, pdd_front, pdd_queue and pdd_back.
//
//   Port group  Role                 Handshake          Payload
//   req_*       request in           req_valid/stall    req_cmd, req_item_value
//   rsp_*       decoded pixel out    rsp_valid/stall    rsp_pixel, rsp_last
//   csr_*       size register write  csr_wr_en          csr_index, csr_data
//
// One request is accepted per cycle while req_stall is low; pixels pass queue, read stage, result register.
// Unless rsp_stall holds it, the back end issues one line store access pair per cycle, which sets the pixel rate.
// Reset is synchronous; the line store is not cleared and needs no clearing pass.
// req_stall rises only while the four-entry queue is full; rsp_stall stalls the back end.
module planar_delta_image_decoder (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic signed [31:0]        req_item_value,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_pixel,
   output logic                      rsp_last,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [pdd_pkg::DIM_W-1:0] csr_data
);

   logic            q_full, q_push, q_pop, q_head_valid;
   pdd_pkg::op_type q_push_op, q_head_op;

   pdd_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_cmd        (req_cmd),
      .req_item_value (req_item_value),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .q_full         (q_full),
      .q_push         (q_push),
      .q_op           (q_push_op)
   );

   pdd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_op    (q_push_op),
      .pop        (q_pop),
      .full       (q_full),
      .head_valid (q_head_valid),
      .head_op    (q_head_op)
   );

   pdd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_head_valid),
      .head_op    (q_head_op),
      .pop        (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_pixel  (rsp_pixel),
      .rsp_last   (rsp_last)
   );

endmodule

FILE: design/pdd_front.sv
// Front end of the planar delta image decoder: size registers, request classification,
// byte gathering and pixel bookkeeping. Produces one operation per decoded pixel.
// Depends on pdd_pkg.
module pdd_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_cmd,
   input  logic signed [31:0]        req_item_value,
   input  logic                      csr_wr_en,
   input  logic                      csr_index,
   input  logic [pdd_pkg::DIM_W-1:0] csr_data,
   input  logic                      q_full,
   output logic                      q_push,
   output pdd_pkg::op_type           q_op
);

   logic [pdd_pkg::DIM_W-1:0]   row_width_ff, row_count_ff;
   logic [7:0]                  code_byte_ff, code_byte_in;
   logic [1:0]                  code_slot_ff, code_slot_in;
   logic [31:0]                 byte_accum_ff, byte_accum_in;
   logic [2:0]                  gathered_ff, gathered_in;
   logic [pdd_pkg::INDEX_W-1:0] pixel_index_ff, pixel_index_in;
   logic [pdd_pkg::RING_AW-1:0] wptr_ff, wptr_in;

   logic [pdd_pkg::DIM_W-1:0]   eff_w, eff_rows;
   logic [pdd_pkg::TOTAL_W-1:0] total, next_count;
   logic                        raw_phase, is_last, accept, emit;
   logic [1:0]                  wcode;
   logic [3:0]                  slot_len, gathered_next;
   logic [31:0]                 accum_next, diff;
   logic [pdd_pkg::RING_AW:0]   up_diff;
   logic [pdd_pkg::RING_AW-1:0] up_addr;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_width_ff <= pdd_pkg::ROW_WIDTH_RESET;
         row_count_ff <= pdd_pkg::ROW_COUNT_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == pdd_pkg::CSR_ROW_WIDTH) begin
            row_width_ff <= csr_data;
         end else begin
            row_count_ff <= csr_data;
         end
      end
   end

   always_comb begin
      if (row_width_ff == '0) begin
         eff_w = pdd_pkg::DIM_W'(1);
      end else if (row_width_ff > pdd_pkg::DIM_W'(pdd_pkg::MAX_WIDTH)) begin
         eff_w = pdd_pkg::DIM_W'(pdd_pkg::MAX_WIDTH);
      end else begin
         eff_w = row_width_ff;
      end
      eff_rows   = (row_count_ff == '0) ? pdd_pkg::DIM_W'(1) : row_count_ff;
      total      = pdd_pkg::TOTAL_W'(eff_w) * pdd_pkg::TOTAL_W'(eff_rows);
      next_count = pdd_pkg::TOTAL_W'(pixel_index_ff) + pdd_pkg::TOTAL_W'(1);
      is_last    = next_count >= total;
      raw_phase  = pdd_pkg::TOTAL_W'(pixel_index_ff)
                   < (pdd_pkg::TOTAL_W'(eff_w) + pdd_pkg::TOTAL_W'(1));
   end

   // The line store is a ring of MAX_WIDTH+1 entries; up sits eff_w (row width clamped) entries back.
   always_comb begin
      up_diff = {1'b0, wptr_ff} - (pdd_pkg::RING_AW+1)'(eff_w);
      if (up_diff[pdd_pkg::RING_AW]) begin
         up_addr = pdd_pkg::RING_AW'(up_diff + (pdd_pkg::RING_AW+1)'(pdd_pkg::RING_DEPTH));
      end else begin
         up_addr = up_diff[pdd_pkg::RING_AW-1:0];
      end
   end

   always_comb begin
      wcode = 2'((code_byte_ff & pdd_pkg::SLOT_MASK[code_slot_ff]) >> {code_slot_ff, 1'b0});
      case (wcode)
         pdd_pkg::WCODE_ONE:  slot_len = 4'd1;
         pdd_pkg::WCODE_TWO:  slot_len = 4'd2;
         pdd_pkg::WCODE_FOUR: slot_len = 4'd4;
         default:             slot_len = 4'd8;
      endcase
      gathered_next = {1'b0, gathered_ff} + 4'd1;
      if (!gathered_ff[2]) begin
         accum_next = byte_accum_ff
                      | (32'(req_item_value[7:0]) << {gathered_ff[1:0], 3'b000});
      end else begin
         accum_next = byte_accum_ff;
      end
      case (wcode)
         pdd_pkg::WCODE_ONE:  diff = {{24{accum_next[7]}}, accum_next[7:0]};
         pdd_pkg::WCODE_TWO:  diff = {{16{accum_next[15]}}, accum_next[15:0]};
         pdd_pkg::WCODE_FOUR: diff = accum_next;
         default:             diff = '0;
      endcase
   end

   always_comb begin
      accept         = req_valid && !q_full;
      emit           = 1'b0;
      code_byte_in   = code_byte_ff;
      code_slot_in   = code_slot_ff;
      byte_accum_in  = byte_accum_ff;
      gathered_in    = gathered_ff;
      pixel_index_in = pixel_index_ff;
      wptr_in        = wptr_ff;
      q_op           = '0;
      q_op.last      = is_last;
      q_op.wr_addr   = wptr_ff;
      q_op.up_addr   = up_addr;
      q_op.ul_addr   = (up_addr == '0) ? pdd_pkg::RING_AW'(pdd_pkg::RING_DEPTH - 1)
                                       : up_addr - pdd_pkg::RING_AW'(1);
      if (accept) begin
         case (req_cmd)
            pdd_pkg::CMD_RAW: begin
               if (raw_phase) begin
                  emit        = 1'b1;
                  q_op.value  = req_item_value;
               end
            end
            pdd_pkg::CMD_CODE: begin
               code_byte_in  = req_item_value[7:0];
               code_slot_in  = '0;
               byte_accum_in = '0;
               gathered_in   = '0;
            end
            pdd_pkg::CMD_DATA: begin
               if (!raw_phase) begin
                  if (gathered_next >= slot_len) begin
                     emit          = 1'b1;
                     q_op.is_delta = 1'b1;
                     q_op.value    = diff;
                     code_slot_in  = code_slot_ff + 2'd1;
                     byte_accum_in = '0;
                     gathered_in   = '0;
                  end else begin
                     byte_accum_in = accum_next;
                     gathered_in   = gathered_next[2:0];
                  end
               end
            end
            default: begin
            end
         endcase
      end
      if (emit) begin
         if (is_last) begin
            pixel_index_in = '0;
            wptr_in        = '0;
            code_slot_in   = '0;
            byte_accum_in  = '0;
            gathered_in    = '0;
         end else begin
            pixel_index_in = pixel_index_ff + pdd_pkg::INDEX_W'(1);
            wptr_in        = (wptr_ff == pdd_pkg::RING_AW'(pdd_pkg::RING_DEPTH - 1))
                             ? '0 : wptr_ff + pdd_pkg::RING_AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         code_byte_ff   <= '0;
         code_slot_ff   <= '0;
         byte_accum_ff  <= '0;
         gathered_ff    <= '0;
         pixel_index_ff <= '0;
         wptr_ff        <= '0;
      end else begin
         code_byte_ff   <= code_byte_in;
         code_slot_ff   <= code_slot_in;
         byte_accum_ff  <= byte_accum_in;
         gathered_ff    <= gathered_in;
         pixel_index_ff <= pixel_index_in;
         wptr_ff        <= wptr_in;
      end
   end

   assign req_stall = q_full;
   assign q_push    = emit;

endmodule

FILE: design/pdd_queue.sv
// Short operation queue between the front end and the back end of the decoder.
// Holds QUEUE_DEPTH operations in registers. Depends on pdd_pkg.
module pdd_queue (
   input  logic            clock,
   input  logic            reset,
   input  logic            push,
   input  pdd_pkg::op_type push_op,
   input  logic            pop,
   output logic            full,
   output logic            head_valid,
   output pdd_pkg::op_type head_op
);

   pdd_pkg::op_type            slot_ff [pdd_pkg::QUEUE_DEPTH];
   logic [pdd_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [pdd_pkg::QPTR_W:0]   count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + pdd_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + pdd_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (pdd_pkg::QPTR_W+1)'(push) - (pdd_pkg::QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_op;
      end
   end

   assign full       = count_ff == (pdd_pkg::QPTR_W+1)'(pdd_pkg::QUEUE_DEPTH);
   assign head_valid = count_ff != '0;
   assign head_op    = slot_ff[rd_ptr_ff];

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (pdd_pkg::QPTR_W+1)'(pdd_pkg::QUEUE_DEPTH))
      else $error("queue count beyond depth");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + (pdd_pkg::QPTR_W+1)'(1))
      else $error("queue count did not follow a push");
`endif

endmodule

FILE: design/pdd_back.sv
// Back end of the decoder: line store ring, planar prediction add and result register.
// Takes operations from the queue, one per cycle while rsp_stall allows. Depends on pdd_pkg.
module pdd_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               head_valid,
   input  pdd_pkg::op_type    head_op,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_pixel,
   output logic               rsp_last
);

   logic [31:0]     line_mem [pdd_pkg::RING_DEPTH];
   logic [31:0]     rd_up_ff, rd_ul_ff, left_ff;
   logic [31:0]     rsp_pixel_ff;
   logic            rsp_last_ff, rsp_valid_ff, y_valid_ff, fwd_up_ff, fwd_ul_ff;
   logic            fwd_up_in, fwd_ul_in;
   pdd_pkg::op_type y_op_ff;

   logic        out_free, y_go, x_go;
   logic [31:0] up, upleft, y_pixel;

   // A pixel written at the same edge as the next read is taken from left_ff instead.
   always_comb begin
      out_free  = !rsp_valid_ff || !rsp_stall;
      y_go      = y_valid_ff && out_free;
      x_go      = head_valid && (!y_valid_ff || y_go);
      fwd_up_in = y_go && (head_op.up_addr == y_op_ff.wr_addr);
      fwd_ul_in = y_go && (head_op.ul_addr == y_op_ff.wr_addr);
      up        = fwd_up_ff ? left_ff : rd_up_ff;
      upleft    = fwd_ul_ff ? left_ff : rd_ul_ff;
      if (y_op_ff.is_delta) begin
         y_pixel = y_op_ff.value + left_ff + up - upleft;
      end else begin
         y_pixel = y_op_ff.value;
      end
   end

   always_ff @(posedge clock) begin
      if (y_go) begin
         line_mem[y_op_ff.wr_addr] <= y_pixel;
      end
      if (x_go) begin
         rd_up_ff <= line_mem[head_op.up_addr];
         rd_ul_ff <= line_mem[head_op.ul_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (x_go) begin
         y_op_ff <= head_op;
      end
      if (y_go) begin
         rsp_pixel_ff <= y_pixel;
         rsp_last_ff  <= y_op_ff.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         y_valid_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fwd_up_ff    <= 1'b0;
         fwd_ul_ff    <= 1'b0;
         left_ff      <= '0;
      end else begin
         if (x_go) begin
            y_valid_ff <= 1'b1;
            fwd_up_ff  <= fwd_up_in;
            fwd_ul_ff  <= fwd_ul_in;
         end else if (y_go) begin
            y_valid_ff <= 1'b0;
         end
         if (y_go) begin
            rsp_valid_ff <= 1'b1;
            left_ff      <= y_pixel;
         end else if (out_free) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign pop       = x_go;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_pixel = rsp_pixel_ff;
   assign rsp_last  = rsp_last_ff;

`ifndef SYNTHESIS
   a_fwd_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(fwd_up_ff && fwd_ul_ff))
      else $error("both neighbors forwarded from one pixel");
   a_left_tracks: assert property (@(posedge clock) disable iff (reset)
      y_go |=> left_ff == $past(y_pixel))
      else $error("left pixel does not hold the last result");
   a_rsp_loaded: assert property (@(posedge clock) disable iff (reset)
      y_go |=> rsp_valid_ff && rsp_pixel_ff == $past(y_pixel))
      else $error("result register not loaded");
`endif

endmodule
